@@ design/cham_pkg.sv @@
`default_nettype none
package cham_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned BlockW   = 32;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned NumIter  = 20;  // four rounds per iteration, 80 rounds
  localparam int unsigned IterW    = 5;
  localparam int unsigned QuarterW = 2;   // selects 4 of the 16 round keys
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 2'd1;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [3:0] quad_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [KeyW-1:0]    data;
  } cfg_wr_t;

  function automatic word_t rol1(input word_t v);
    return {v[14:0], v[15]};
  endfunction

  function automatic word_t rol8(input word_t v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic word_t rol11(input word_t v);
    return {v[4:0], v[15:5]};
  endfunction

endpackage
`default_nettype wire

@@ design/cham64_128_block_encrypt.sv @@
// Each item runs through the round unit once per iteration, then loads into the output register once it is free.
// The round unit does four rounds per cycle and is reused for every iteration of an item,
// so the block takes no new item while one is still in its rounds.
// A new item is taken in the cycle the previous result moves to the output register.
// Reset (async, active low) clears the sequencer, output valid and both key registers.
`default_nettype none
module cham64_128_block_encrypt
  import cham_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [BlockW-1:0]   block_first_i,
  input  wire logic [BlockW-1:0]   block_second_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [BlockW-1:0]        cipher_first_o,
  output logic [BlockW-1:0]        cipher_second_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [KeyW-1:0]     cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [IterW-1:0] IterLast = IterW'(NumIter - 1);

  logic [1:0]       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  quad_t            x_q, x_d, x_next;
  quad_t            rk;
  logic             out_valid_q, out_valid_d;
  logic [BlockW-1:0] out_first_q, out_second_q;
  logic             out_free, in_acc, out_load;
  cfg_wr_t          cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = '{valid: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};

  cham_key_sched u_key_sched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .quarter_i(iter_q[QuarterW-1:0]),
    .rk_o     (rk)
  );

  cham_round_unit u_round_unit (
    .x_i   (x_q),
    .iter_i(iter_q),
    .rk_i  (rk),
    .x_o   (x_next)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == StFin) && out_free;
  assign in_stall_o = !((state_q == StIdle) || out_load);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    x_d         = x_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: ;
      StRun: begin
        x_d    = x_next;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterLast) state_d = StFin;
      end
      StFin: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (in_acc) begin
      state_d = StRun;
      iter_d  = '0;
      x_d[0]  = block_first_i[BlockW-1:WordW];
      x_d[1]  = block_first_i[WordW-1:0];
      x_d[2]  = block_second_i[BlockW-1:WordW];
      x_d[3]  = block_second_i[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (out_load) begin
      out_first_q  <= {x_q[0], x_q[1]};
      out_second_q <= {x_q[2], x_q[3]};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = out_first_q;
  assign cipher_second_o = out_second_q;

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StRun) && (iter_q == '0))
    else $error("accepted item did not start at iteration zero");

  a_last_iter_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) && (iter_q == IterLast) && !in_acc |=> state_q == StFin)
    else $error("sequencer missed the last iteration");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == StFin)
    else $error("result shown before the rounds finished");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> in_stall_o)
    else $error("input taken while rounds in progress");

endmodule
`default_nettype wire

@@ design/cham_key_sched.sv @@
`default_nettype none
module cham_key_sched
  import cham_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_wr_t             cfg_wr_i,
  input  wire logic [QuarterW-1:0] quarter_i,
  output quad_t                    rk_o
);

  logic [KeyW-1:0] key_low_q, key_high_q;
  word_t           kw [8];
  word_t           rk_all [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_wr_i.valid) begin
      unique case (cfg_wr_i.index)
        CfgKeyLow:  key_low_q  <= cfg_wr_i.data;
        CfgKeyHigh: key_high_q <= cfg_wr_i.data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      kw[j]   = key_low_q[WordW*j +: WordW];
      kw[j+4] = key_high_q[WordW*j +: WordW];
    end
    for (int j = 0; j < 8; j++) begin
      rk_all[j]           = kw[j] ^ rol1(kw[j]) ^ rol8(kw[j]);
      rk_all[(j + 8) ^ 1] = kw[j] ^ rol1(kw[j]) ^ rol11(kw[j]);
    end
    for (int j = 0; j < 4; j++) begin
      rk_o[j] = rk_all[{quarter_i, 2'(j)}];
    end
  end

endmodule
`default_nettype wire

@@ design/cham_round_unit.sv @@
`default_nettype none
module cham_round_unit
  import cham_pkg::*;
(
  input  wire quad_t             x_i,
  input  wire logic [IterW-1:0]  iter_i,
  input  wire quad_t             rk_i,
  output quad_t                  x_o
);

  // Four chained rounds; the round number is {iter, j}, so parity follows j.
  always_comb begin
    quad_t cur;
    word_t lhs, rhs, sum, nw;
    cur = x_i;
    for (int j = 0; j < 4; j++) begin
      lhs = cur[0] ^ {{(WordW-IterW-2){1'b0}}, iter_i, 2'(j)};
      if ((j % 2) == 0) begin
        rhs = rol1(cur[1]) ^ rk_i[j];
        sum = lhs + rhs;
        nw  = rol8(sum);
      end else begin
        rhs = rol8(cur[1]) ^ rk_i[j];
        sum = lhs + rhs;
        nw  = rol1(sum);
      end
      cur[0] = cur[1];
      cur[1] = cur[2];
      cur[2] = cur[3];
      cur[3] = nw;
    end
    x_o = cur;
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb
  import cham_pkg::*;
();

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 210;

  // register indexes that map to no key register
  localparam logic [CfgIdxW-1:0] CfgNoReg2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNoReg3 = 2'd3;

  typedef struct packed {
    logic [BlockW-1:0] first;
    logic [BlockW-1:0] second;
  } pair_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [BlockW-1:0]   block_first_i = '0;
  logic [BlockW-1:0]   block_second_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [BlockW-1:0]   cipher_first_o;
  logic [BlockW-1:0]   cipher_second_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [KeyW-1:0]     cfg_data_i = '0;

  pair_t       plain_q[$];
  pair_t       cipher_q[$];
  logic [KeyW-1:0] key_lo = '0;
  logic [KeyW-1:0] key_hi = '0;
  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  logic        idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;

  cham64_128_block_encrypt dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .block_first_i  (block_first_i),
    .block_second_i (block_second_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cipher_first_o (cipher_first_o),
    .cipher_second_o(cipher_second_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic word_t rotl16(input word_t v, input int unsigned n);
    return (v << n) | (v >> (16 - n));
  endfunction

  // CHAM-64/128 encryption of {X0, X1, X2, X3} under key {K7..K4, K3..K0}
  function automatic pair_t cham_encrypt(input logic [2*BlockW-1:0] blk,
                                         input logic [KeyW-1:0] klo,
                                         input logic [KeyW-1:0] khi);
    word_t rk[16];
    word_t x[4];
    word_t kw;
    word_t rhs;
    word_t sum;
    logic [2*KeyW-1:0] kall;
    kall = {khi, klo};
    for (int j = 0; j < 8; j++) begin
      kw = kall[16*j +: 16];
      rk[j] = kw ^ rotl16(kw, 1) ^ rotl16(kw, 8);
      rk[(j + 8) ^ 1] = kw ^ rotl16(kw, 1) ^ rotl16(kw, 11);
    end
    x[0] = blk[63:48];
    x[1] = blk[47:32];
    x[2] = blk[31:16];
    x[3] = blk[15:0];
    for (int r = 0; r < 80; r++) begin
      if (r % 2 == 0) begin
        rhs = rotl16(x[1], 1) ^ rk[r % 16];
        sum = (x[0] ^ word_t'(r)) + rhs;
        sum = rotl16(sum, 8);
      end else begin
        rhs = rotl16(x[1], 8) ^ rk[r % 16];
        sum = (x[0] ^ word_t'(r)) + rhs;
        sum = rotl16(sum, 1);
      end
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = sum;
    end
    return {x[0], x[1], x[2], x[3]};
  endfunction

  task automatic report_mismatch(input string what, input logic [BlockW-1:0] got,
                                 input logic [BlockW-1:0] want);
    if (errors < 50)
      $display("mismatch %s: got %h, want %h, cycle %0d", what, got, want, cycle_cnt);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // sample both channels, check results, predict new ones
  always @(posedge clk_i) begin
    pair_t want;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    cfg_fire <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("result with no block pending", cipher_first_o, '0);
        end else begin
          want = cipher_q.pop_front();
          if (cipher_first_o !== want.first)
            report_mismatch("cipher_first", cipher_first_o, want.first);
          if (cipher_second_o !== want.second)
            report_mismatch("cipher_second", cipher_second_o, want.second);
        end
      end
      if (in_valid_i && !in_stall_o)
        cipher_q.push_back(cham_encrypt({block_first_i, block_second_i}, key_lo, key_hi));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgKeyLow:  key_lo = cfg_data_i;
          CfgKeyHigh: key_hi = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // sender: hold an item until taken, then maybe insert a gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (plain_q.size() > 0) begin
        in_valid_i <= 1'b1;
        block_first_i <= plain_q[0].first;
        block_second_i <= plain_q[0].second;
        void'(plain_q.pop_front());
        if (idle_on && $urandom_range(0, 7) == 0)
          send_gap <= $urandom_range(1, 16);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    logic [KeyW-1:0] kl;
    logic [KeyW-1:0] kh;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset key is all zero
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hffff_ffff, 32'hffff_ffff);
    push_block(32'h8000_8000, 32'h8000_8000);
    push_block(32'h0001_0001, 32'h0001_0001);
    push_block(32'h5555_aaaa, 32'haaaa_5555);
    push_block(32'h0000_ffff, 32'hffff_0000);
    wait_idle();

    set_key('1, '1);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hffff_ffff, 32'hffff_ffff);
    push_block(32'h7fff_7fff, 32'hfffe_fffe);
    push_block(32'h1234_5678, 32'h9abc_def0);
    wait_idle();

    // writes to unmapped indexes must leave the key alone
    write_reg(CfgNoReg2, '0);
    write_reg(CfgNoReg3, '0);
    push_block(32'h0000_0000, 32'hffff_ffff);
    push_block(32'hdead_beef, 32'h0bad_f00d);
    wait_idle();

    set_key('1, '0);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hffff_ffff, 32'h0000_0001);
    wait_idle();

    set_key('0, '1);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'h8000_0001, 32'h0001_8000);
    wait_idle();

    set_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    push_block(32'h0011_2233, 32'h4455_6677);
    push_block(32'h8899_aabb, 32'hccdd_eeff);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      kl = rand_key();
      kh = rand_key();
      if ($urandom_range(0, 1)) begin
        write_reg(CfgKeyHigh, kh);
        write_reg(CfgKeyLow, kl);
      end else begin
        set_key(kl, kh);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CfgNoReg2 : CfgNoReg3, rand_key());
      if (ph == NumPhases - 1)
        idle_on = 1'b0;
      repeat (PhaseItems) push_block(rand_half(), rand_half());
      // back up the block behind a long receiver hold
      if (ph == 2)
        hold_asks++;
      wait_idle();
    end

    repeat (DrainWait) @(negedge clk_i);
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  task automatic push_block(input logic [BlockW-1:0] a, input logic [BlockW-1:0] b);
    plain_q.push_back({a, b});
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (plain_q.size() != 0 || in_valid_i || cipher_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i);
    while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_key(input logic [KeyW-1:0] lo, input logic [KeyW-1:0] hi);
    write_reg(CfgKeyLow, lo);
    write_reg(CfgKeyHigh, hi);
  endtask

  function automatic logic [BlockW-1:0] rand_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

endmodule
`default_nettype wire
